>>> hdl/sfc_pkg.sv
package sfc_pkg;

  localparam int TAPS = 512;
  localparam int AW = $clog2(TAPS);
  localparam int CW = $clog2(TAPS + 1);
  localparam int SAMPLE_W = 16;
  localparam int PROD_W = 2 * SAMPLE_W;
  localparam int ACC_W = PROD_W + AW;
  localparam int TAP_COUNT_W = 10;
  localparam int SHIFT_W = 5;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_PUSH = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic REG_TAP_COUNT = 1'b0;
  localparam logic REG_OUTPUT_SHIFT = 1'b1;

  typedef struct packed {
    logic          hist_we;
    logic [AW-1:0] hist_waddr;
    logic          coef_we;
    logic [AW-1:0] coef_waddr;
    logic          rd_en;
    logic [AW-1:0] hist_raddr;
    logic [AW-1:0] coef_raddr;
    logic          rd_live;
    logic          acc_clr;
  } lane_ctrl_t;

endpackage

>>> hdl/sfc_lane.sv
module sfc_lane (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sfc_pkg::lane_ctrl_t                   ctrl,
  input  logic signed [sfc_pkg::SAMPLE_W-1:0]   hist_wdata,
  input  logic signed [sfc_pkg::SAMPLE_W-1:0]   coef_wdata,
  output logic signed [sfc_pkg::ACC_W-1:0]      acc
);
  import sfc_pkg::*;

  logic signed [SAMPLE_W-1:0] hist_mem [TAPS];
  logic signed [SAMPLE_W-1:0] coef_mem [TAPS];

  logic signed [SAMPLE_W-1:0] hist_q;
  logic signed [SAMPLE_W-1:0] coef_q;
  logic signed [PROD_W-1:0]   prod;
  logic                       v1;
  logic                       live1;
  logic                       v2;

  always_ff @(posedge clk) begin
    if (ctrl.hist_we) begin
      hist_mem[ctrl.hist_waddr] <= hist_wdata;
    end
    if (ctrl.coef_we) begin
      coef_mem[ctrl.coef_waddr] <= coef_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      hist_q <= hist_mem[ctrl.hist_raddr];
      coef_q <= coef_mem[ctrl.coef_raddr];
    end
  end

  // history entries older than the last clear read as zero
  always_ff @(posedge clk) begin
    prod <= live1 ? PROD_W'(hist_q * coef_q) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      live1 <= 1'b0;
      v2    <= 1'b0;
    end else begin
      v1    <= ctrl.rd_en;
      live1 <= ctrl.rd_en & ctrl.rd_live;
      v2    <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc_clr) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

endmodule

>>> hdl/sfc_merge.sv
module sfc_merge (
  input  logic                                clk,
  input  logic                                load,
  input  logic [sfc_pkg::SHIFT_W-1:0]         shift,
  input  logic signed [sfc_pkg::ACC_W-1:0]    acc_left,
  input  logic signed [sfc_pkg::ACC_W-1:0]    acc_right,
  output logic signed [sfc_pkg::SAMPLE_W-1:0] out_left,
  output logic signed [sfc_pkg::SAMPLE_W-1:0] out_right,
  output logic                                clipped
);
  import sfc_pkg::*;

  localparam logic signed [ACC_W-1:0] MAX_OUT = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] MIN_OUT = -ACC_W'(32768);

  logic signed [ACC_W-1:0]    rnd;
  logic signed [ACC_W-1:0]    sum_l;
  logic signed [ACC_W-1:0]    sum_r;
  logic signed [ACC_W-1:0]    sh_l;
  logic signed [ACC_W-1:0]    sh_r;
  logic signed [SAMPLE_W-1:0] sat_l;
  logic signed [SAMPLE_W-1:0] sat_r;
  logic                       clip_l;
  logic                       clip_r;

  // round half up, then arithmetic shift
  always_comb begin
    rnd   = (shift == '0) ? '0 : (ACC_W'(1) << (shift - SHIFT_W'(1)));
    sum_l = acc_left + rnd;
    sum_r = acc_right + rnd;
    sh_l  = sum_l >>> shift;
    sh_r  = sum_r >>> shift;
  end

  always_comb begin
    clip_l = 1'b1;
    if (sh_l > MAX_OUT) begin
      sat_l = 16'sh7fff;
    end else if (sh_l < MIN_OUT) begin
      sat_l = -16'sh8000;
    end else begin
      sat_l  = sh_l[SAMPLE_W-1:0];
      clip_l = 1'b0;
    end
    clip_r = 1'b1;
    if (sh_r > MAX_OUT) begin
      sat_r = 16'sh7fff;
    end else if (sh_r < MIN_OUT) begin
      sat_r = -16'sh8000;
    end else begin
      sat_r  = sh_r[SAMPLE_W-1:0];
      clip_r = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_left  <= sat_l;
      out_right <= sat_r;
      clipped   <= clip_l | clip_r;
    end
  end

endmodule

>>> hdl/stereo_fir_convolver.sv
// channel   dir   handshake                 payload
// s_axis    in    s_tvalid / s_tready       s_tdata (taps, samples), s_tuser (action)
// m_axis    out   m_tvalid / m_tready       m_tdata (out_left, out_right), m_tuser (clipped)
// cfg       in    cfg_we                    cfg_index, cfg_data
//
// a load or clear leaves the block idle and ready; a sample push runs n taps,
// n = min(tap_count, 512), with one multiply-accumulate per lane per tap
// through the coefficient and history memory read ports
// rst is synchronous; history is emptied at once through a fill count, no sweep
// a finished result waits in the output register; a new item is taken meanwhile,
// and a following push stalls only at its scaling step until the slot frees
module stereo_fir_convolver (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tap_index[8:0], tap_left[24:9], tap_right[40:25], sample_left[56:41],
  // sample_right[72:57], zero fill[79:73]
  input  logic [79:0] s_tdata,
  // action[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_left[15:0], out_right[31:16]
  output logic [31:0] m_tdata,
  // clipped[0]
  output logic [0:0]  m_tuser,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [sfc_pkg::TAP_COUNT_W-1:0] cfg_data
);
  import sfc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAC   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_SCALE = 3'd3;

  logic [2:0]             state;
  logic [CW-1:0]          k;
  logic [CW-1:0]          n_taps;
  logic [CW-1:0]          fill;
  logic [AW-1:0]          newest;
  logic [1:0]             drain;
  logic [TAP_COUNT_W-1:0] tap_count;
  logic [SHIFT_W-1:0]     output_shift;

  logic                   in_xfer;
  logic                   push;
  logic                   load_taps;
  logic                   clear;
  logic [AW-1:0]          newest_next;
  logic [CW-1:0]          n_sat;
  logic                   merge_load;
  lane_ctrl_t             ctrl;

  logic [AW-1:0]               tap_index;
  logic signed [SAMPLE_W-1:0]  tap_left;
  logic signed [SAMPLE_W-1:0]  tap_right;
  logic signed [SAMPLE_W-1:0]  sample_left;
  logic signed [SAMPLE_W-1:0]  sample_right;
  logic signed [ACC_W-1:0]     acc_left;
  logic signed [ACC_W-1:0]     acc_right;
  logic signed [SAMPLE_W-1:0]  out_left;
  logic signed [SAMPLE_W-1:0]  out_right;
  logic                        clipped;

  assign tap_index    = s_tdata[AW-1:0];
  assign tap_left     = s_tdata[24:9];
  assign tap_right    = s_tdata[40:25];
  assign sample_left  = s_tdata[56:41];
  assign sample_right = s_tdata[72:57];

  assign s_tready  = (state == ST_IDLE);
  assign in_xfer   = s_tvalid & s_tready;
  assign push      = in_xfer & (s_tuser == ACT_PUSH);
  assign load_taps = in_xfer & (s_tuser == ACT_LOAD);
  assign clear     = in_xfer & (s_tuser == ACT_CLEAR);

  assign newest_next = newest + AW'(1);
  assign n_sat = (32'(tap_count) > 32'(TAPS)) ? CW'(TAPS) : CW'(tap_count);
  assign merge_load = (state == ST_SCALE) & (~m_tvalid | m_tready);

  always_comb begin
    ctrl.hist_we    = push;
    ctrl.hist_waddr = newest_next;
    ctrl.coef_we    = load_taps;
    ctrl.coef_waddr = tap_index;
    ctrl.rd_en      = (state == ST_MAC) & (k != n_taps);
    ctrl.hist_raddr = newest - k[AW-1:0];
    ctrl.coef_raddr = k[AW-1:0];
    ctrl.rd_live    = (k < fill);
    ctrl.acc_clr    = push;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count    <= TAP_COUNT_W'(512);
      output_shift <= SHIFT_W'(15);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TAP_COUNT:    tap_count    <= cfg_data;
        REG_OUTPUT_SHIFT: output_shift <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      k        <= '0;
      n_taps   <= '0;
      fill     <= '0;
      newest   <= '0;
      drain    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if (merge_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid & m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (push) begin
            newest <= newest_next;
            if (fill != CW'(TAPS)) begin
              fill <= fill + CW'(1);
            end
            n_taps <= n_sat;
            k      <= '0;
            state  <= ST_MAC;
          end else if (clear) begin
            newest <= '0;
            fill   <= '0;
          end
        end
        ST_MAC: begin
          if (k == n_taps) begin
            drain <= 2'd2;
            state <= ST_DRAIN;
          end else begin
            k <= k + CW'(1);
          end
        end
        ST_DRAIN: begin
          // wait for the read, multiply and accumulate stages to empty
          if (drain == 2'd0) begin
            state <= ST_SCALE;
          end else begin
            drain <= drain - 2'd1;
          end
        end
        ST_SCALE: begin
          if (merge_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  sfc_lane u_lane_left (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .hist_wdata (sample_left),
    .coef_wdata (tap_left),
    .acc        (acc_left)
  );

  sfc_lane u_lane_right (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .hist_wdata (sample_right),
    .coef_wdata (tap_right),
    .acc        (acc_right)
  );

  sfc_merge u_merge (
    .clk       (clk),
    .load      (merge_load),
    .shift     (output_shift),
    .acc_left  (acc_left),
    .acc_right (acc_right),
    .out_left  (out_left),
    .out_right (out_right),
    .clipped   (clipped)
  );

  assign m_tdata = {out_right, out_left};
  assign m_tuser = clipped;

endmodule

>>> hdl/sfc_checker.sv
module sfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [79:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [0:0]  m_tuser,
  input logic        cfg_we,
  input logic [0:0]  cfg_index,
  input logic [sfc_pkg::TAP_COUNT_W-1:0] cfg_data
);
  import sfc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // only a push makes a result
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser != ACT_PUSH && !m_tvalid |=> !m_tvalid)
    else $error("result without a sample push");

  a_push_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == ACT_PUSH |=> !s_tready)
    else $error("input taken during filter pass");

  // a clip flag means at least one channel sits at a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      m_tdata[15:0] == 16'h7fff || m_tdata[15:0] == 16'h8000 ||
      m_tdata[31:16] == 16'h7fff || m_tdata[31:16] == 16'h8000)
    else $error("clip flag without saturated output");

endmodule

bind stereo_fir_convolver sfc_checker u_sfc_checker (.*);
